FILE: rtl/core/field_strength_color_ramp_unit_macros.svh
// Assertion macros shared by the field strength color ramp RTL
`ifndef FIELD_STRENGTH_COLOR_RAMP_UNIT_MACROS_SVH
`define FIELD_STRENGTH_COLOR_RAMP_UNIT_MACROS_SVH

// antecedent holds now, consequent (may start with a delay) follows
`define FSCR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("fscr check failed");

// consequent holds in the cycle after the antecedent
`define FSCR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fscr check failed");

`endif

FILE: rtl/core/fscr_pkg.sv
// Types, constants and tables of the field strength color ramp
package fscr_pkg;

	localparam int BAND_COUNT = 6;
	localparam int IDX_W      = $clog2(BAND_COUNT + 1);
	localparam int MAG_W      = 19;
	localparam int D_W        = 18;
	localparam int D_LO_W     = 9;
	localparam int D_HI_W     = D_W - D_LO_W;
	localparam int RCP_W      = 26;
	localparam int PP_W       = RCP_W + D_LO_W;
	localparam int FRAC_W     = 16;
	localparam int ACC_W      = 26;

	localparam logic [1:0] POLE_NONE  = 2'd0;
	localparam logic [1:0] POLE_NORTH = 2'd1;
	localparam logic [1:0] POLE_SOUTH = 2'd2;

	localparam logic [1:0] SCL_DIM    = 2'd0;
	localparam logic [1:0] SCL_LOW    = 2'd1;
	localparam logic [1:0] SCL_MID    = 2'd2;
	localparam logic [1:0] SCL_FULL   = 2'd3;

	localparam logic [MAG_W-1:0] SCL_LIM_DIM = 19'd77;
	localparam logic [MAG_W-1:0] SCL_LIM_LOW = 19'd256;
	localparam logic [MAG_W-1:0] SCL_LIM_MID = 19'd2560;

	localparam logic [7:0] TINT_LIM = 8'd220;
	localparam logic [7:0] TINT_ADD = 8'd30;

	localparam int CH_R = 2;
	localparam int CH_G = 1;
	localparam int CH_B = 0;

	typedef logic [7:0] chan_t;
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] pole;
		logic [1:0] scl;
	} side_t;

	localparam logic [MAG_W-1:0] BAND_LIMIT [BAND_COUNT] = '{
		19'd128, 19'd256, 19'd768, 19'd2560, 19'd12800, 19'd204800
	};

	localparam rgb_t BAND_RGB [BAND_COUNT] = '{
		{8'd0,   8'd30,  8'd255},
		{8'd0,   8'd200, 8'd255},
		{8'd0,   8'd255, 8'd80},
		{8'd255, 8'd255, 8'd0},
		{8'd255, 8'd140, 8'd0},
		{8'd255, 8'd20,  8'd0}
	};

	localparam logic [RCP_W-1:0] SEG_RECIP [BAND_COUNT] = '{
		26'd0, 26'd33554432, 26'd8388608, 26'd2396745, 26'd419430, 26'd22369
	};

	function automatic logic [8:0] scale_factor(input logic [1:0] scl);
		logic [8:0] f;
		case (scl)
			SCL_DIM:  f = 9'd51;
			SCL_LOW:  f = 9'd102;
			SCL_MID:  f = 9'd179;
			default:  f = 9'd256;
		endcase
		return f;
	endfunction

	function automatic chan_t tint(input chan_t c);
		return (c < TINT_LIM) ? chan_t'(c + TINT_ADD) : 8'd255;
	endfunction

endpackage

FILE: rtl/core/field_strength_color_ramp_unit.sv
// Top level of the field strength color ramp: magnitude and pole to RGB
//
//   channel   handshake          payload                 width
//   request   start / busy       magnitude, pole         19, 2
//   result    done (strobe)      red, green, blue        8, 8, 8
//
// A request is taken at every clock edge with start high and busy low.
// Each request gives one result, one per cycle sustained.
// Five register stages: band search, split multiply, fraction, blend, tint/scale.
// busy is high only during reset and until the run flag is registered high after it.
// The receiver cannot stall; the pipeline advances every cycle.
`include "field_strength_color_ramp_unit_macros.svh"

module field_strength_color_ramp_unit import fscr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [MAG_W-1:0] magnitude,
	input  logic [1:0]       pole,
	output logic             done,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	logic             run_q;
	logic             take;
	logic             black_req;
	side_t            side_s1;
	side_t            side_s3;
	rgb_t             base_s1;
	rgb_t             next_s1;
	rgb_t             base_s3;
	rgb_t             next_s3;
	logic [D_W-1:0]   d_s1;
	logic [RCP_W-1:0] rcp_s1;
	logic [FRAC_W-1:0] frac_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign busy = ~run_q;
	assign take = start & run_q;
	assign black_req = take && pole == POLE_NONE && magnitude >= BAND_LIMIT[BAND_COUNT-1];

	fscr_band_select u_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.magnitude (magnitude),
		.pole      (pole),
		.side_s1   (side_s1),
		.base_s1   (base_s1),
		.next_s1   (next_s1),
		.d_s1      (d_s1),
		.rcp_s1    (rcp_s1)
	);

	fscr_frac_mul u_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.side_s1 (side_s1),
		.base_s1 (base_s1),
		.next_s1 (next_s1),
		.d_s1    (d_s1),
		.rcp_s1  (rcp_s1),
		.side_s3 (side_s3),
		.base_s3 (base_s3),
		.next_s3 (next_s3),
		.frac_s3 (frac_s3)
	);

	fscr_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.side_s3 (side_s3),
		.base_s3 (base_s3),
		.next_s3 (next_s3),
		.frac_s3 (frac_s3),
		.done    (done),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

	`FSCR_ASSERT_IMPL(a_req_gives_result, start && !busy, ##5 done)
	`FSCR_ASSERT_IMPL(a_result_has_req, done, $past(start && !busy, 5))
	`FSCR_ASSERT_IMPL(a_black_above_top, black_req, ##5 (red == 8'd0 && green == 8'd0 && blue == 8'd0))

endmodule

FILE: rtl/core/fscr_band_select.sv
// Stage 1: threshold search, segment operands and brightness band
module fscr_band_select import fscr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [MAG_W-1:0] magnitude,
	input  logic [1:0]       pole,
	output side_t            side_s1,
	output rgb_t             base_s1,
	output rgb_t             next_s1,
	output logic [D_W-1:0]   d_s1,
	output logic [RCP_W-1:0] rcp_s1
);

	logic [IDX_W-1:0] seg;
	logic [IDX_W-1:0] seg_m1;
	rgb_t             base_c;
	rgb_t             next_c;
	logic [D_W-1:0]   d_c;
	logic [RCP_W-1:0] rcp_c;
	logic [1:0]       scl_c;

	always_comb begin
		seg = IDX_W'(BAND_COUNT);
		for (int k = BAND_COUNT - 1; k >= 0; k--) begin
			if (magnitude < BAND_LIMIT[k]) begin
				seg = IDX_W'(k);
			end
		end
		seg_m1 = IDX_W'(seg - 1'b1);
		if (seg == '0) begin
			base_c = BAND_RGB[0];
			next_c = BAND_RGB[0];
			d_c    = '0;
			rcp_c  = '0;
		end else if (seg == IDX_W'(BAND_COUNT)) begin
			base_c = '0;
			next_c = '0;
			d_c    = '0;
			rcp_c  = '0;
		end else begin
			base_c = BAND_RGB[seg_m1];
			next_c = BAND_RGB[seg];
			d_c    = D_W'(magnitude - BAND_LIMIT[seg_m1]);
			rcp_c  = SEG_RECIP[seg];
		end
		if (magnitude < SCL_LIM_DIM) begin
			scl_c = SCL_DIM;
		end else if (magnitude < SCL_LIM_LOW) begin
			scl_c = SCL_LOW;
		end else if (magnitude < SCL_LIM_MID) begin
			scl_c = SCL_MID;
		end else begin
			scl_c = SCL_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.vld  <= take;
			side_s1.pole <= pole;
			side_s1.scl  <= scl_c;
		end
	end

	always_ff @(posedge clk) begin
		base_s1 <= base_c;
		next_s1 <= next_c;
		d_s1    <= d_c;
		rcp_s1  <= rcp_c;
	end

endmodule

FILE: rtl/core/fscr_frac_mul.sv
// Stages 2 and 3: split product of offset and reciprocal, fraction
module fscr_frac_mul import fscr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  side_t             side_s1,
	input  rgb_t              base_s1,
	input  rgb_t              next_s1,
	input  logic [D_W-1:0]    d_s1,
	input  logic [RCP_W-1:0]  rcp_s1,
	output side_t             side_s3,
	output rgb_t              base_s3,
	output rgb_t              next_s3,
	output logic [FRAC_W-1:0] frac_s3
);

	localparam int SUM_W = PP_W + D_LO_W + 1;

	side_t            side_s2;
	rgb_t             base_s2;
	rgb_t             next_s2;
	logic [PP_W-1:0]  pp_lo_s2;
	logic [PP_W-1:0]  pp_hi_s2;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-FRAC_W-1:0] f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		base_s2  <= base_s1;
		next_s2  <= next_s1;
		pp_lo_s2 <= PP_W'(d_s1[D_LO_W-1:0] * rcp_s1);
		pp_hi_s2 <= PP_W'(d_s1[D_W-1:D_LO_W] * rcp_s1);
	end

	always_comb begin
		sum = SUM_W'({pp_hi_s2, {D_LO_W{1'b0}}}) + SUM_W'(pp_lo_s2);
		f   = sum[SUM_W-1:FRAC_W];
	end

	always_ff @(posedge clk) begin
		base_s3 <= base_s2;
		next_s3 <= next_s2;
		frac_s3 <= (|f[SUM_W-FRAC_W-1:FRAC_W]) ? '1 : f[FRAC_W-1:0];
	end

endmodule

FILE: rtl/core/fscr_blend.sv
// Stages 4 and 5: channel interpolation, pole tint, brightness scaling
module fscr_blend import fscr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  side_t             side_s3,
	input  rgb_t              base_s3,
	input  rgb_t              next_s3,
	input  logic [FRAC_W-1:0] frac_s3,
	output logic              done,
	output chan_t             red,
	output chan_t             green,
	output chan_t             blue
);

	side_t side_s4;
	rgb_t  mix_c;
	rgb_t  mix_s4;
	rgb_t  tint_c;
	rgb_t  out_c;

	always_comb begin
		logic signed [8:0]       diff;
		logic signed [ACC_W-1:0] acc;
		for (int k = 0; k < 3; k++) begin
			diff = $signed({1'b0, next_s3[k]}) - $signed({1'b0, base_s3[k]});
			acc  = $signed({2'b00, base_s3[k], 16'b0}) + $signed({1'b0, frac_s3}) * diff;
			mix_c[k] = acc[ACC_W-1] ? 8'd0 : acc[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			done    <= 1'b0;
		end else begin
			side_s4 <= side_s3;
			done    <= side_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		mix_s4 <= mix_c;
	end

	always_comb begin
		logic [16:0] prod;
		tint_c = mix_s4;
		if (side_s4.pole == POLE_NORTH) begin
			tint_c[CH_R] = tint(mix_s4[CH_R]);
		end else if (side_s4.pole == POLE_SOUTH) begin
			tint_c[CH_B] = tint(mix_s4[CH_B]);
		end
		for (int k = 0; k < 3; k++) begin
			prod     = tint_c[k] * scale_factor(side_s4.scl);
			out_c[k] = prod[15:8];
		end
	end

	always_ff @(posedge clk) begin
		red   <= out_c[CH_R];
		green <= out_c[CH_G];
		blue  <= out_c[CH_B];
	end

endmodule
